// ===== rtl/mrpts_pkg.sv =====
`default_nettype none

package mrpts_pkg;

    localparam int TIME_BITS     = 48;
    localparam int DURATION_BITS = 16;
    localparam int NUM_TIMERS    = 4;
    localparam int SEL_BITS      = 2;
    localparam int ACT_BITS      = 2;
    localparam int CFG_IDX_BITS  = 8;

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_START = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_ARM   = 2'd2;

    // timer selects
    localparam logic [SEL_BITS-1:0] TMR_JOIN     = 2'd0;
    localparam logic [SEL_BITS-1:0] TMR_LEAVE    = 2'd1;
    localparam logic [SEL_BITS-1:0] TMR_LEAVEALL = 2'd2;
    localparam logic [SEL_BITS-1:0] TMR_PERIODIC = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_JOIN_DURATION     = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAVE_DURATION    = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIODIC_DURATION = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAVEALL_NOMINAL  = 8'd3;

    localparam logic [DURATION_BITS-1:0] RST_JOIN_DURATION     = 16'd200;
    localparam logic [DURATION_BITS-1:0] RST_LEAVE_DURATION    = 16'd1000;
    localparam logic [DURATION_BITS-1:0] RST_PERIODIC_DURATION = 16'd1000;
    localparam logic [DURATION_BITS-1:0] RST_LEAVEALL_NOMINAL  = 16'd10000;

    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [DURATION_BITS-1:0] t_dur;

    typedef struct packed {
        t_dur join_dur;
        t_dur leave_dur;
        t_dur periodic_dur;
        t_dur leaveall_nom;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/mrpts_deadline_calc.sv =====
`default_nettype none

module mrpts_deadline_calc (
    input  wire mrpts_pkg::t_cfg                    i_cfg,
    input  wire logic [mrpts_pkg::SEL_BITS-1:0]     i_sel,
    input  wire mrpts_pkg::t_time                   i_now,
    input  wire mrpts_pkg::t_dur                    i_offset,
    output mrpts_pkg::t_time                        o_deadline
);

    mrpts_pkg::t_dur                        lim;
    mrpts_pkg::t_dur                        off_sat;
    logic [mrpts_pkg::DURATION_BITS:0]      dur;
    logic [mrpts_pkg::TIME_BITS:0]          sum;

    always_comb begin
        // leaveall offset saturates at nominal minus one (zero for a zero nominal)
        lim     = (i_cfg.leaveall_nom != '0) ? i_cfg.leaveall_nom - 1'b1 : '0;
        off_sat = (i_offset > lim) ? lim : i_offset;
        case (i_sel)
            mrpts_pkg::TMR_JOIN:     dur = {1'b0, i_cfg.join_dur};
            mrpts_pkg::TMR_LEAVE:    dur = {1'b0, i_cfg.leave_dur};
            mrpts_pkg::TMR_LEAVEALL: dur = {1'b0, i_cfg.leaveall_nom >> 1} + {1'b0, off_sat};
            mrpts_pkg::TMR_PERIODIC: dur = {1'b0, i_cfg.periodic_dur};
            default:                 dur = '0;
        endcase
        sum = {1'b0, i_now}
            + {{(mrpts_pkg::TIME_BITS - mrpts_pkg::DURATION_BITS){1'b0}}, dur};
        // clamp at the top of the time range
        o_deadline = sum[mrpts_pkg::TIME_BITS] ? '1 : sum[mrpts_pkg::TIME_BITS-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/mrpts_earliest.sv =====
`default_nettype none

module mrpts_earliest (
    input  wire logic [mrpts_pkg::NUM_TIMERS-1:0]   i_running,
    input  wire mrpts_pkg::t_time                   i_deadline [mrpts_pkg::NUM_TIMERS],
    output mrpts_pkg::t_time                        o_earliest,
    output logic                                    o_none
);

    mrpts_pkg::t_time v   [mrpts_pkg::NUM_TIMERS];
    mrpts_pkg::t_time m01;
    mrpts_pkg::t_time m23;

    always_comb begin
        // idle timers read as all ones so they never win
        for (int i = 0; i < mrpts_pkg::NUM_TIMERS; i++) begin
            v[i] = i_running[i] ? i_deadline[i] : '1;
        end
        m01        = (v[1] < v[0]) ? v[1] : v[0];
        m23        = (v[3] < v[2]) ? v[3] : v[2];
        o_earliest = (m23 < m01) ? m23 : m01;
        o_none     = (i_running == '0);
    end

endmodule

`default_nettype wire

// ===== rtl/mrp_protocol_timer_set_core.sv =====
`default_nettype none

// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: action, timer_select
//           |     |                               | tdata: now, random_offset
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: expired x4, earliest_deadline
//           |     |                               | tuser: none_running
// cfg       | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while m_axis_tready stays high. A taken beat sits in the input
// register and moves into the result register once that one is free or being read. Between
// the two registers one combinational pass does the deadline adder, the timer update and the
// earliest-deadline search over the updated timers. Reset (i_rst_n low, synchronous) empties
// both registers, idles all four timers and loads the default durations. A full result
// register holds while m_axis_tready is low; s_axis_tready drops when both registers hold
// beats and m_axis_tready is low. Config writes are always taken.

module mrp_protocol_timer_set_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] action, [3:2] timer_select
    input  wire logic [3:0]  s_axis_tuser,
    // [47:0] now, [63:48] random_offset
    input  wire logic [63:0] s_axis_tdata,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] expired_join, [1] expired_leave, [2] expired_leaveall, [3] expired_periodic,
    // [51:4] earliest_deadline, [55:52] zero
    output logic [55:0]      m_axis_tdata,
    // [0] none_running
    output logic [0:0]       m_axis_tuser,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [mrpts_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int NT = mrpts_pkg::NUM_TIMERS;
    localparam int TB = mrpts_pkg::TIME_BITS;
    localparam int DB = mrpts_pkg::DURATION_BITS;

    // configuration
    mrpts_pkg::t_cfg r_cfg;

    // input stage
    logic                              r_a_vld;
    logic [mrpts_pkg::ACT_BITS-1:0]    r_a_action;
    logic [mrpts_pkg::SEL_BITS-1:0]    r_a_sel;
    mrpts_pkg::t_time                  r_a_now;
    mrpts_pkg::t_dur                   r_a_offset;

    // timer state
    mrpts_pkg::t_time                  r_deadline [NT];
    logic [NT-1:0]                     r_running;

    // result register
    logic                              r_o_vld;
    logic [NT-1:0]                     r_o_exp;
    mrpts_pkg::t_time                  r_o_earliest;
    logic                              r_o_none;

    logic                              o_adv;
    logic                              a_move;
    logic                              arm_en;
    logic [NT-1:0]                     n_running;
    logic [NT-1:0]                     n_exp;
    mrpts_pkg::t_time                  n_deadline [NT];
    mrpts_pkg::t_time                  new_deadline;
    mrpts_pkg::t_time                  earliest;
    logic                              none;

    // pipeline moves: the result register frees first, then the input register
    assign o_adv         = !r_o_vld || m_axis_tready;
    assign a_move        = r_a_vld && o_adv;
    assign s_axis_tready = !r_a_vld || o_adv;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {4'b0, r_o_earliest, r_o_exp};
    assign m_axis_tuser  = r_o_none;

    mrpts_deadline_calc u_calc (
        .i_cfg      (r_cfg),
        .i_sel      (r_a_sel),
        .i_now      (r_a_now),
        .i_offset   (r_a_offset),
        .o_deadline (new_deadline)
    );

    // search the timers as they stand after this beat's update
    mrpts_earliest u_earliest (
        .i_running  (n_running),
        .i_deadline (n_deadline),
        .o_earliest (earliest),
        .o_none     (none)
    );

    // expire on tick, arm on start (idle only) or rearm; other codes leave state alone
    always_comb begin
        n_running = r_running;
        n_exp     = '0;
        arm_en    = 1'b0;
        for (int i = 0; i < NT; i++) begin
            n_deadline[i] = r_deadline[i];
        end
        case (r_a_action)
            mrpts_pkg::ACT_TICK: begin
                for (int i = 0; i < NT; i++) begin
                    if (r_running[i] && (r_deadline[i] <= r_a_now)) begin
                        n_exp[i]     = 1'b1;
                        n_running[i] = 1'b0;
                    end
                end
            end
            mrpts_pkg::ACT_START: arm_en = !r_running[r_a_sel];
            mrpts_pkg::ACT_ARM:   arm_en = 1'b1;
            default:              arm_en = 1'b0;
        endcase
        if (arm_en) begin
            n_running[r_a_sel]  = 1'b1;
            n_deadline[r_a_sel] = new_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.join_dur     <= mrpts_pkg::RST_JOIN_DURATION;
            r_cfg.leave_dur    <= mrpts_pkg::RST_LEAVE_DURATION;
            r_cfg.periodic_dur <= mrpts_pkg::RST_PERIODIC_DURATION;
            r_cfg.leaveall_nom <= mrpts_pkg::RST_LEAVEALL_NOMINAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mrpts_pkg::REG_JOIN_DURATION:     r_cfg.join_dur     <= i_cfg_data[DB-1:0];
                mrpts_pkg::REG_LEAVE_DURATION:    r_cfg.leave_dur    <= i_cfg_data[DB-1:0];
                mrpts_pkg::REG_PERIODIC_DURATION: r_cfg.periodic_dur <= i_cfg_data[DB-1:0];
                mrpts_pkg::REG_LEAVEALL_NOMINAL:  r_cfg.leaveall_nom <= i_cfg_data[DB-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_vld <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_a_action <= s_axis_tuser[1:0];
            r_a_sel    <= s_axis_tuser[3:2];
            r_a_now    <= s_axis_tdata[TB-1:0];
            r_a_offset <= s_axis_tdata[TB+DB-1:TB];
        end
    end

    // timer state: commit the update as the beat moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            for (int i = 0; i < NT; i++) begin
                r_deadline[i] <= '0;
            end
        end else if (a_move) begin
            r_running <= n_running;
            for (int i = 0; i < NT; i++) begin
                r_deadline[i] <= n_deadline[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_adv) begin
            r_o_vld <= r_a_vld;
        end
        if (a_move) begin
            r_o_exp      <= n_exp;
            r_o_earliest <= earliest;
            r_o_none     <= none;
        end
    end

    // no running timer means the earliest deadline reads all ones
    a_none_earliest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_none) |-> (r_o_earliest == '1))
        else $error("none_running set with a pending deadline");

    // a rearm leaves the chosen timer running
    a_arm_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && (r_a_action == mrpts_pkg::ACT_ARM)) |=> r_running[$past(r_a_sel)])
        else $error("rearmed timer not running");

    // an expired timer is cleared
    a_exp_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && (r_a_action == mrpts_pkg::ACT_TICK)) |=> ((r_running & $past(n_exp)) == '0))
        else $error("expired timer still running");

    // input side stalls only with both registers full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_a_vld && r_o_vld))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/mrp_protocol_timer_set_core_tb.sv =====
`default_nettype none

module mrp_protocol_timer_set_core_tb;
    import mrpts_pkg::*;

    // action code that leaves every timer untouched
    localparam logic [ACT_BITS-1:0] ACT_IDLE = 2'd3;
    // register indexes that the block must ignore
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_TOP = 8'd255;

    localparam t_time TIME_MAX     = '1;
    localparam int    RAND_PHASES  = 14;
    localparam int    PHASE_ITEMS  = 100;
    localparam int    HOLD_PHASE   = 3;
    localparam int    HOLD_CYCLES  = 250;
    localparam int    DRAIN_CYCLES = 8;
    localparam int    CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [NUM_TIMERS-1:0] expired;
        t_time                 earliest;
        logic                  none_running;
    } t_timer_result;

    // Shadow of the four timers plus the queue of results they should produce.
    class t_deadline_tracker;
        t_time         deadline [NUM_TIMERS];
        bit            armed [NUM_TIMERS];
        t_dur          join_dur;
        t_dur          leave_dur;
        t_dur          periodic_dur;
        t_dur          leaveall_nom;
        t_timer_result expected_results [$];
        int            mismatches;

        function new();
            mismatches = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                deadline[i] = '0;
                armed[i]    = 1'b0;
            end
            join_dur     = RST_JOIN_DURATION;
            leave_dur    = RST_LEAVE_DURATION;
            periodic_dur = RST_PERIODIC_DURATION;
            leaveall_nom = RST_LEAVEALL_NOMINAL;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, t_dur val);
            case (idx)
                REG_JOIN_DURATION:     join_dur     = val;
                REG_LEAVE_DURATION:    leave_dur    = val;
                REG_PERIODIC_DURATION: periodic_dur = val;
                REG_LEAVEALL_NOMINAL:  leaveall_nom = val;
                default: ;
            endcase
        endfunction

        function logic [DURATION_BITS:0] duration(logic [SEL_BITS-1:0] sel, t_dur offset);
            t_dur lim;
            case (sel)
                TMR_JOIN:     return {1'b0, join_dur};
                TMR_LEAVE:    return {1'b0, leave_dur};
                TMR_PERIODIC: return {1'b0, periodic_dur};
                default: begin
                    // leaveall: half nominal plus an offset clipped below nominal
                    lim = (leaveall_nom == '0) ? '0 : leaveall_nom - 1'b1;
                    if (offset > lim)
                        offset = lim;
                    return {2'b0, leaveall_nom[DURATION_BITS-1:1]} + {1'b0, offset};
                end
            endcase
        endfunction

        function t_time due_at(t_time now, logic [DURATION_BITS:0] dur);
            logic [TIME_BITS:0] sum;
            sum = {1'b0, now} + {{(TIME_BITS-DURATION_BITS){1'b0}}, dur};
            return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
        endfunction

        function void note_item(logic [ACT_BITS-1:0] act, logic [SEL_BITS-1:0] sel,
                                t_time now, t_dur offset);
            t_timer_result res;
            res.expired      = '0;
            res.earliest     = TIME_MAX;
            res.none_running = 1'b1;
            if (act == ACT_TICK) begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (armed[i] && deadline[i] <= now) begin
                        res.expired[i] = 1'b1;
                        armed[i]       = 1'b0;
                    end
                end
            end else if (act == ACT_START || act == ACT_ARM) begin
                if (act == ACT_ARM || !armed[sel]) begin
                    deadline[sel] = due_at(now, duration(sel, offset));
                    armed[sel]    = 1'b1;
                end
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (armed[i]) begin
                    res.none_running = 1'b0;
                    if (deadline[i] < res.earliest)
                        res.earliest = deadline[i];
                end
            end
            expected_results.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h, want %0h", what, got, want);
            mismatches++;
        endtask

        task check_result(logic [55:0] data, logic [0:0] user);
            t_timer_result res;
            if (expected_results.size() == 0) begin
                report("unexpected result beat", 64'(data), '0);
                return;
            end
            res = expected_results.pop_front();
            for (int i = 0; i < NUM_TIMERS; i++)
                if (data[i] !== res.expired[i])
                    report($sformatf("expired flag %0d", i), 64'(data[i]),
                           64'(res.expired[i]));
            if (data[51:4] !== res.earliest)
                report("earliest_deadline", 64'(data[51:4]), 64'(res.earliest));
            if (data[55:52] !== 4'b0)
                report("tdata pad", 64'(data[55:52]), '0);
            if (user[0] !== res.none_running)
                report("none_running", 64'(user[0]), 64'(res.none_running));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [1:0] action, [3:2] timer_select
    logic [3:0]  s_axis_tuser;
    // [47:0] now, [63:48] random_offset
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] expired_join, [1] expired_leave, [2] expired_leaveall, [3] expired_periodic,
    // [51:4] earliest_deadline, [55:52] zero
    logic [55:0] m_axis_tdata;
    // [0] none_running
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    t_deadline_tracker tracker;
    bit tx_idle_on;
    bit rx_stall_on;
    bit hold_req;
    int cycle_cnt;

    mrp_protocol_timer_set_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run; the bound covers the slowest legal run many times over.
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("mrp_protocol_timer_set_core verification failed");
            $finish;
        end
    end

    // Result side: drop tready in random bursts, and once on request hold it low
    // long enough for the pipeline to fill and push back on the input.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Compare every accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Offer one input beat and hold it until the block takes it.
    task automatic send_item(input logic [ACT_BITS-1:0] act, input logic [SEL_BITS-1:0] sel,
                             input t_time now, input t_dur off);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {sel, act};
        s_axis_tdata  = {off, now};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_item(act, sel, now, off);
    endtask

    // Now and then insert an idle burst of random length.
    task automatic maybe_gap();
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_dur val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Load one of four duration profiles: short, all maximum, zero or one, any value.
    // Returns the longest timer span so that time can be advanced at a matching pace.
    task automatic configure_phase(input int kind, output int span);
        t_dur v [4];
        for (int i = 0; i < 4; i++) begin
            case (kind)
                0:       v[i] = t_dur'($urandom_range(1, 64));
                1:       v[i] = '1;
                2:       v[i] = t_dur'($urandom_range(0, 1));
                default: v[i] = t_dur'($urandom);
            endcase
        end
        if (kind == 0)
            v[3] = t_dur'($urandom_range(2, 128));
        wait_drained();
        write_reg(REG_JOIN_DURATION, v[0]);
        write_reg(REG_LEAVE_DURATION, v[1]);
        write_reg(REG_PERIODIC_DURATION, v[2]);
        write_reg(REG_LEAVEALL_NOMINAL, v[3]);
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_BITS'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)),
                      t_dur'($urandom));
        span = int'(v[3]) + int'(v[3]) / 2;
        for (int i = 0; i < 3; i++)
            if (int'(v[i]) > span)
                span = int'(v[i]);
    endtask

    initial begin
        t_time                 clock_ms;
        int                    span;
        int                    stride;
        int                    roll;
        bit                    quiet;
        logic [ACT_BITS-1:0]   act;
        logic [SEL_BITS-1:0]   sel;
        t_dur                  off;

        tracker       = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        tx_idle_on    = 1'b0;
        rx_stall_on   = 1'b0;
        hold_req      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, default durations: idle tick, start versus arm,
        // leaveall offset clipping, exact and saturated deadlines, expiry edges.
        send_item(ACT_TICK, TMR_PERIODIC, '0, '0);
        send_item(ACT_START, TMR_JOIN, 48'd0, '0);
        send_item(ACT_START, TMR_JOIN, 48'd50, '0);
        send_item(ACT_ARM, TMR_JOIN, 48'd100, '0);
        send_item(ACT_START, TMR_LEAVEALL, 48'd100, '0);
        send_item(ACT_ARM, TMR_LEAVEALL, 48'd100, '1);
        send_item(ACT_START, TMR_LEAVE, 48'd150, 16'h1234);
        send_item(ACT_START, TMR_PERIODIC, 48'd150, '0);
        send_item(ACT_IDLE, TMR_JOIN, 48'd160, '1);
        send_item(ACT_TICK, TMR_JOIN, 48'd299, '0);
        send_item(ACT_TICK, TMR_LEAVE, 48'd300, '0);
        send_item(ACT_TICK, TMR_LEAVEALL, 48'd1150, '0);
        send_item(ACT_TICK, TMR_PERIODIC, 48'd15099, '0);
        send_item(ACT_ARM, TMR_PERIODIC, TIME_MAX - 48'd10, '0);
        send_item(ACT_ARM, TMR_JOIN, TIME_MAX - 48'd200, '0);
        send_item(ACT_START, TMR_LEAVE, 48'hAAAA_AAAA_AAAA, 16'hAAAA);
        send_item(ACT_TICK, TMR_JOIN, 48'h5555_5555_5555, 16'h5555);
        send_item(ACT_TICK, TMR_JOIN, TIME_MAX, '0);

        // Zero durations expire on the very next tick; stray indexes change nothing.
        wait_drained();
        write_reg(REG_LEAVEALL_NOMINAL, '0);
        write_reg(REG_JOIN_DURATION, '0);
        write_reg(REG_UNUSED_LOW, 16'd7);
        write_reg(REG_UNUSED_TOP, '1);
        send_item(ACT_ARM, TMR_LEAVEALL, 48'd5000, '1);
        send_item(ACT_START, TMR_JOIN, 48'd5000, '0);
        send_item(ACT_TICK, TMR_JOIN, 48'd5000, '0);
        wait_drained();
        write_reg(REG_LEAVEALL_NOMINAL, 16'd1);
        send_item(ACT_ARM, TMR_LEAVEALL, 48'd6000, 16'd1);
        wait_drained();
        write_reg(REG_LEAVEALL_NOMINAL, '1);
        send_item(ACT_ARM, TMR_LEAVEALL, 48'd7000, '1);
        send_item(ACT_TICK, TMR_LEAVE, 48'd7000, '0);

        // Random part: mostly monotonic time with rare jumps, backwards and to the top.
        clock_ms = '0;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            quiet = (phase >= RAND_PHASES - 2);
            configure_phase(phase % 4, span);
            tx_idle_on  = !quiet && phase != HOLD_PHASE && $urandom_range(0, 3) != 0;
            rx_stall_on = !quiet && $urandom_range(0, 3) != 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == HOLD_PHASE && k == 10)
                    hold_req = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    clock_ms = t_time'({$urandom, $urandom});
                end else if (roll < 4) begin
                    clock_ms = TIME_MAX - t_time'($urandom_range(0, 2 * span));
                end else begin
                    stride = $urandom_range(0, span / 6 + 2);
                    if (TIME_MAX - clock_ms < t_time'(stride))
                        clock_ms = TIME_MAX;
                    else
                        clock_ms = clock_ms + t_time'(stride);
                end
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    act = ACT_TICK;
                else if (roll < 68)
                    act = ACT_START;
                else if (roll < 95)
                    act = ACT_ARM;
                else
                    act = ACT_IDLE;
                sel  = SEL_BITS'($urandom_range(0, 3));
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    off = '0;
                else if (roll < 20)
                    off = '1;
                else if (roll < 30)
                    off = tracker.leaveall_nom - 1'b1 + t_dur'($urandom_range(0, 2));
                else
                    off = t_dur'($urandom);
                send_item(act, sel, clock_ms, off);
                maybe_gap();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("mrp_protocol_timer_set_core verification clean");
        else
            $display("mrp_protocol_timer_set_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== mrp_protocol_timer_set_core.f =====
rtl/mrpts_pkg.sv
rtl/mrpts_deadline_calc.sv
rtl/mrpts_earliest.sv
rtl/mrp_protocol_timer_set_core.sv
tb/mrp_protocol_timer_set_core_tb.sv
